>>> hdl/pulse_window_speed_cadence_top_macros.svh
// assertion macros shared by the tachometer modules
// expects clk_i and rst_ni in the scope of every use
`ifndef PULSE_WINDOW_SPEED_CADENCE_TOP_MACROS_SVH
`define PULSE_WINDOW_SPEED_CADENCE_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define PWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define PWSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/pwsc_pkg.sv
// shared types and constants of the windowed pulse tachometer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pwsc_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned WINDOW_MAX_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 64;

  // fixed field widths
  localparam int unsigned TIME_FIELD_W = 64;
  localparam int unsigned K_W          = 32;
  localparam int unsigned WS_W         = 5;
  localparam int unsigned HELD_W       = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned IN_TDATA_W   = 64;
  localparam int unsigned OUT_FIELDS_W = K_W + K_W + HELD_W + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // register reset values and limits
  localparam logic [WS_W-1:0] WS_MIN        = 5'd2;
  localparam logic [WS_W-1:0] WS_RESET      = 5'd6;
  localparam logic [K_W-1:0]  TIMEOUT_RESET = 32'd3000000;
  localparam logic [K_W-1:0]  SPEED_K_RESET = 32'd2000000000;
  localparam logic [K_W-1:0]  CAD_K_RESET   = 32'd60000000;

  // item kinds carried in tuser
  typedef enum logic {
    OP_PULSE  = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_WDOG_TMO    = 2'd1,
    REG_SPEED_K     = 2'd2,
    REG_CADENCE_K   = 2'd3
  } reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WDOG,
    ST_SPAN,
    ST_DIV_S_GO,
    ST_DIV_S_WAIT,
    ST_DIV_C_GO,
    ST_DIV_C_WAIT,
    ST_DONE
  } pwsc_state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/pwsc_ring_mem.sv
// stamp ring storage: one write port, one read port, registered read data
// depends on pwsc_pkg
`timescale 1ns / 1ps

module pwsc_ring_mem
  import pwsc_pkg::*;
#(
  parameter int unsigned DEPTH  = WINDOW_MAX_DEF,
  parameter int unsigned ADDR_W = $clog2(WINDOW_MAX_DEF),
  parameter int unsigned DATA_W = TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pwsc_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on pwsc_pkg and the assertion macro header
`timescale 1ns / 1ps

`include "pulse_window_speed_cadence_top_macros.svh"

module pwsc_divider
  import pwsc_pkg::*;
#(
  parameter int unsigned DVD_W = K_W + $clog2(WINDOW_MAX_DEF + 1),
  parameter int unsigned DSR_W = TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output div_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q, dsr_q;
  logic [DSR_W:0]   rem_shift, diff;
  logic             fits;

  // one trial subtraction; a zero divisor yields all ones
  assign rem_shift = {rem_q, quo_q[DVD_W-1]};
  assign diff      = rem_shift - {1'b0, dsr_q};
  assign fits      = ~diff[DSR_W] | (dsr_q == '0);

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `PWSC_ASSERT(a_done_follows_busy, done_q |-> $past(busy_q), "divider done without a run")
  `PWSC_ASSERT(a_busy_has_steps, busy_q |-> (cnt_q != '0), "divider busy with no steps left")
  `PWSC_ASSERT(a_no_restart, start_i |-> !busy_q, "divider started while running")

endmodule

>>> hdl/pulse_window_speed_cadence_top.sv
// windowed pulse tachometer, top level; depends on pwsc_pkg, pwsc_ring_mem,
// pwsc_divider and the assertion macro header
//
// Items enter on the s_axis channel: tuser[0] is the kind (0 crank pulse,
// 1 update), tdata[63:0] the microsecond time. Every item gives exactly one
// result on m_axis: held speed x10, held cadence, stamps in the window and
// the watchdog-cleared flag. A pulse writes its stamp into the ring memory
// and goes straight to the done state. An update reads the newest stamp
// for the watchdog, then the oldest stamp for the span, and runs two
// quotients of 32 plus the count width bits through one shared bit-serial
// divider. An update that clears or finds fewer than two stamps skips
// the divider. One item is worked on at a time.
// The result sits in an output register: a stalled receiver holds it there
// while the next item is taken in; that item then waits for the register.
// Reset empties the window, zeroes the held values and loads the default
// registers; the stamp memory needs no clearing. Configuration writes are
// taken at any edge with cfg_we_i high and belong to idle periods.
`timescale 1ns / 1ps

`include "pulse_window_speed_cadence_top_macros.svh"

module pulse_window_speed_cadence_top
  import pwsc_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // item input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [63:0] time_us
  input  logic [0:0]             s_axis_tuser,  // [0] opcode
  // result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] speed_x10, [63:32] cadence,
                                                // [68:64] pulses_held, [69] watchdog_cleared
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned CMP_W  = ((CNT_W > WS_W) ? CNT_W : WS_W) + 1;
  localparam int unsigned PROD_W = K_W + CNT_W;
  localparam int unsigned PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;

  // configuration registers
  logic [WS_W-1:0] ws_q;
  logic [K_W-1:0]  tmo_q, speed_k_q, cad_k_q;
  logic [WS_W-1:0] ws_in, ws_clamp;

  // window and held state
  logic [IDX_W-1:0] oldest_q;
  logic [CNT_W-1:0] count_q;
  logic [K_W-1:0]   speed_q, cad_q;
  logic             cleared_q;
  logic             m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // datapath registers
  logic [TIME_BITS-1:0] now_q, newest_q, span_q;
  logic [PROD_W-1:0]    prod_q;

  pwsc_state_e state_q, state_d;

  // control signals
  logic                 accept, is_pulse, wd_fire, few, out_load;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_raddr, wr_idx, newest_idx, oldest_next;
  logic [SUM_W-1:0]     wr_sum, newest_sum;
  logic [TIME_BITS-1:0] now_in, rdata, age;
  logic [CNT_W-1:0]     n_intervals;
  logic                 div_start;
  logic [PROD_W-1:0]    quotient;
  div_stat_t            div_stat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign is_pulse      = (op_e'(s_axis_tuser[0]) == OP_PULSE);
  assign now_in        = s_axis_tdata[TIME_BITS-1:0];

  // ring addressing modulo the window depth
  assign wr_sum      = SUM_W'(oldest_q) + SUM_W'(count_q);
  assign newest_sum  = wr_sum - SUM_W'(1);
  assign wr_idx      = (wr_sum >= SUM_W'(WINDOW_MAX)) ? IDX_W'(wr_sum - SUM_W'(WINDOW_MAX))
                                                      : IDX_W'(wr_sum);
  assign newest_idx  = (newest_sum >= SUM_W'(WINDOW_MAX))
                       ? IDX_W'(newest_sum - SUM_W'(WINDOW_MAX)) : IDX_W'(newest_sum);
  assign oldest_next = (oldest_q == IDX_W'(WINDOW_MAX - 1)) ? '0 : oldest_q + IDX_W'(1);

  // watchdog age against the newest stamp, wrapping
  assign age         = now_q - rdata;
  assign wd_fire     = (count_q != '0) && (age > TIME_BITS'(tmo_q));
  assign few         = (count_q < CNT_W'(2));
  assign n_intervals = count_q - CNT_W'(1);

  assign mem_we = accept & is_pulse;

  pwsc_ring_mem #(
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (IDX_W),
    .DATA_W (TIME_BITS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx),
    .wdata_i (now_in),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  pwsc_divider #(
    .DVD_W (PROD_W),
    .DSR_W (TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, memory reads, divider starts and result load
  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_raddr = newest_idx;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_pulse) begin
            state_d = ST_DONE;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_WDOG;
          end
        end
      end
      ST_WDOG: begin
        if (wd_fire || few) begin
          state_d = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = oldest_q;
          state_d   = ST_SPAN;
        end
      end
      ST_SPAN: state_d = ST_DIV_S_GO;
      ST_DIV_S_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_S_WAIT;
      end
      ST_DIV_S_WAIT: begin
        if (div_stat.done) begin
          state_d = ST_DIV_C_GO;
        end
      end
      ST_DIV_C_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_C_WAIT;
      end
      ST_DIV_C_WAIT: begin
        if (div_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  // window size write clamped to the legal range
  assign ws_in = cfg_data_i[WS_W-1:0];
  always_comb begin
    priority if (ws_in < WS_MIN) begin
      ws_clamp = WS_MIN;
    end else if (int'(ws_in) > WINDOW_MAX) begin
      ws_clamp = WS_W'(WINDOW_MAX);
    end else begin
      ws_clamp = ws_in;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q      <= WS_RESET;
      tmo_q     <= TIMEOUT_RESET;
      speed_k_q <= SPEED_K_RESET;
      cad_k_q   <= CAD_K_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_WINDOW_SIZE: ws_q      <= ws_clamp;
        REG_WDOG_TMO:    tmo_q     <= cfg_data_i;
        REG_SPEED_K:     speed_k_q <= cfg_data_i;
        REG_CADENCE_K:   cad_k_q   <= cfg_data_i;
      endcase
    end
  end

  // window bookkeeping and held results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      count_q   <= '0;
      speed_q   <= '0;
      cad_q     <= '0;
      cleared_q <= 1'b0;
    end else begin
      if (accept) begin
        cleared_q <= 1'b0;
        if (is_pulse) begin
          if (CMP_W'(count_q) >= CMP_W'(ws_q)) begin
            oldest_q <= oldest_next;
          end else begin
            count_q <= count_q + CNT_W'(1);
          end
        end
      end
      if (state_q == ST_WDOG) begin
        if (wd_fire) begin
          oldest_q  <= '0;
          count_q   <= '0;
          cleared_q <= 1'b1;
        end
        if (wd_fire || few) begin
          speed_q <= '0;
          cad_q   <= '0;
        end
      end
      if (state_q == ST_DIV_S_WAIT && div_stat.done) begin
        speed_q <= quotient[K_W-1:0];
      end
      if (state_q == ST_DIV_C_WAIT && div_stat.done) begin
        cad_q <= quotient[K_W-1:0];
      end
    end
  end

  // stamps, span and scaled interval count
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_in;
    end
    if (state_q == ST_WDOG) begin
      newest_q <= rdata;
    end
    if (state_q == ST_SPAN) begin
      span_q <= newest_q - rdata;
      prod_q <= PROD_W'(n_intervals) * PROD_W'(speed_k_q);
    end
    if (state_q == ST_DIV_S_WAIT && div_stat.done) begin
      prod_q <= PROD_W'(n_intervals) * PROD_W'(cad_k_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {{PAD_W{1'b0}}, cleared_q, HELD_W'(count_q), cad_q, speed_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `PWSC_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(WINDOW_MAX), "window count overflow")
  `PWSC_ASSERT(a_pulse_fills, (accept && is_pulse) |=> (count_q != '0), "pulse left window empty")
  `PWSC_ASSERT(a_cleared_empty, (out_load && cleared_q) |-> (count_q == '0), "cleared with stamps")
  `PWSC_ASSERT(a_load_on_free, out_load |-> (!m_valid_q || m_axis_tready), "result overwritten")

endmodule
